### design/countdown_timer_controller_core_macros.svh
// Assertion helpers shared by the timer RTL.
// Each macro expects clk and arst_n in scope.
`ifndef COUNTDOWN_TIMER_CONTROLLER_CORE_MACROS_SVH
`define COUNTDOWN_TIMER_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication
`define CDT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CDT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cdt_pkg.sv
`default_nettype none

package cdt_pkg;

	// Timer tick rate default
	localparam int TICKS_PER_SECOND_DEF = 100;

	// Preset limits and steps
	localparam int          PRESET_W          = 9;
	localparam int          PRESET_MAX        = 5 * 60;
	localparam int          LARGE_STEP_FACTOR = 60;
	localparam logic [8:0]  PRESET_STEP_RESET = 9'd10;

	// Beeper
	localparam int          TONE_W       = 24;
	localparam logic [23:0] TONE_START   = 24'd3072;
	localparam logic [23:0] TONE_STEP    = 24'd100;
	localparam int          BEEP_SECONDS = 9;

	// Elapsed seconds saturate at 16 bits
	localparam int          ELAPSED_W = 16;

	typedef enum logic [1:0] {
		MODE_SET     = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_PAUSED  = 2'd2,
		MODE_BEEPING = 2'd3
	} mode_t;

	// One polling step, tick in the lowest bit
	typedef struct packed {
		logic button_start_stop;
		logic button_recall;
		logic button_large_step;
		logic button_small_step;
		logic tick;
	} item_t;

	// One result, mode in the lowest bits
	typedef struct packed {
		logic [TONE_W-1:0]   beep_tone;
		logic                beeper_on;
		logic                show_remaining;
		logic [PRESET_W-1:0] remaining_seconds;
		logic [PRESET_W-1:0] preset_seconds;
		mode_t               mode;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

### design/cdt_engine.sv
`default_nettype none

`include "countdown_timer_controller_core_macros.svh"

module cdt_engine import cdt_pkg::*; #(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step_en,
	input  wire item_t               item,
	input  wire logic [PRESET_W-1:0] preset_step,
	output result_t                  result
);

	// Tick count kept as quotient and remainder by the tick rate, so no divider
	localparam longint unsigned CNT_MAX = 64'hFFFF_FFFF;
	localparam longint unsigned DMAX    = CNT_MAX / TICKS_PER_SECOND;
	localparam longint unsigned MMAX    = CNT_MAX % TICKS_PER_SECOND;
	localparam int DW  = $clog2(DMAX + 1);
	localparam int MW  = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
	// Beep phase over two seconds, beep tick count up to one past the limit
	localparam int PHW = $clog2(2 * TICKS_PER_SECOND);
	localparam int BCW = $clog2(BEEP_SECONDS * TICKS_PER_SECOND + 2);
	localparam logic [DW-1:0]  DIV_LAST   = DW'(DMAX);
	localparam logic [MW-1:0]  MOD_LAST   = MW'(MMAX);
	localparam logic [MW-1:0]  MOD_TOP    = MW'(TICKS_PER_SECOND - 1);
	localparam logic [PHW-1:0] PH_HALF    = PHW'(TICKS_PER_SECOND);
	localparam logic [PHW-1:0] PH_TOP     = PHW'(2 * TICKS_PER_SECOND - 1);
	localparam logic [BCW-1:0] BEEP_LIMIT = BCW'(BEEP_SECONDS * TICKS_PER_SECOND);
	localparam logic [15:0]    PRESET_LIM = 16'(PRESET_MAX);

	mode_t               mode_q, n_mode;
	logic                entry_q, n_entry;
	logic [PRESET_W-1:0] preset_q, n_preset;
	logic [PRESET_W-1:0] saved_q, n_saved;
	logic [DW-1:0]       cur_div_q, n_cur_div;
	logic [MW-1:0]       cur_mod_q, n_cur_mod;
	logic [DW-1:0]       run_div_q, n_run_div;
	logic [MW-1:0]       run_mod_q, n_run_mod;
	logic [ELAPSED_W-1:0] elapsed_q, n_elapsed;
	logic [PHW-1:0]      phase_q, n_phase;
	logic [BCW-1:0]      beep_cnt_q, n_beep_cnt;
	logic [TONE_W-1:0]   tone_q, n_tone;
	logic                beeper_q, n_beeper;
	logic                ran_set;
	logic [15:0]         large_amount;

	// Add to the preset, wrapping to zero past the maximum
	function automatic logic [PRESET_W-1:0] add_preset(input logic [PRESET_W-1:0] base,
			input logic [15:0] amount);
		logic [15:0] sum;
		sum = 16'(base) + amount;
		return (sum <= PRESET_LIM) ? sum[PRESET_W-1:0] : '0;
	endfunction

	assign large_amount = 16'(preset_step) * 16'(LARGE_STEP_FACTOR);

	// Mode handlers for one step
	always_comb begin
		n_mode     = mode_q;
		n_entry    = entry_q;
		n_preset   = preset_q;
		n_saved    = saved_q;
		n_cur_div  = cur_div_q;
		n_cur_mod  = cur_mod_q;
		n_run_div  = run_div_q;
		n_run_mod  = run_mod_q;
		n_elapsed  = elapsed_q;
		n_phase    = phase_q;
		n_beep_cnt = beep_cnt_q;
		n_tone     = tone_q;
		n_beeper   = beeper_q;
		ran_set    = 1'b0;
		case (mode_q)
			MODE_SET: begin
				ran_set  = 1'b1;
				n_entry  = 1'b1;
				n_preset = entry_q ? preset_q : '0;
				// small, recall, large, start in that order
				if (item.button_small_step) begin
					n_preset = add_preset(n_preset, 16'(preset_step));
				end
				if (item.button_recall) begin
					n_preset = saved_q;
				end
				if (item.button_large_step) begin
					n_preset = add_preset(n_preset, large_amount);
				end
				if (item.button_start_stop) begin
					n_saved   = n_preset;
					n_mode    = MODE_RUNNING;
					n_entry   = 1'b0;
					n_run_div = '0;
					n_run_mod = '0;
				end
			end
			MODE_RUNNING: begin
				n_entry = 1'b1;
				if (!entry_q) begin
					// entry tick is dropped: count restarts from the saved run
					n_cur_div = run_div_q;
					n_cur_mod = run_mod_q;
				end else if (item.tick) begin
					if (cur_div_q == DIV_LAST && cur_mod_q == MOD_LAST) begin
						n_cur_div = '0;
						n_cur_mod = '0;
					end else if (cur_mod_q == MOD_TOP) begin
						n_cur_div = cur_div_q + 1'b1;
						n_cur_mod = '0;
					end else begin
						n_cur_mod = cur_mod_q + 1'b1;
					end
				end
				n_elapsed = (n_cur_div > DW'(16'hFFFF)) ? 16'hFFFF
				                                        : n_cur_div[ELAPSED_W-1:0];
				if (n_elapsed >= 16'(preset_q)) begin
					n_mode  = MODE_BEEPING;
					n_entry = 1'b0;
				end
				// pause takes precedence over reaching the preset
				if (item.button_start_stop) begin
					n_mode    = MODE_PAUSED;
					n_entry   = 1'b0;
					n_run_div = n_cur_div;
					n_run_mod = n_cur_mod;
				end
			end
			MODE_PAUSED: begin
				n_entry = 1'b1;
				if (item.button_start_stop && elapsed_q < 16'(preset_q)) begin
					n_mode  = MODE_RUNNING;
					n_entry = 1'b0;
				end
				if (item.button_small_step || item.button_large_step) begin
					n_mode  = MODE_SET;
					n_entry = 1'b0;
				end
			end
			default: begin
				// beeping
				n_entry = 1'b1;
				if (!entry_q) begin
					n_beep_cnt = '0;
					n_phase    = '0;
					n_tone     = TONE_START;
				end else if (item.tick) begin
					n_beep_cnt = beep_cnt_q + 1'b1;
					n_phase    = (phase_q == PH_TOP) ? '0 : phase_q + 1'b1;
				end
				if (n_phase < PH_HALF) begin
					n_tone   = n_tone + TONE_STEP;
					n_beeper = 1'b1;
				end
				if (n_phase > PH_HALF) begin
					n_beeper = 1'b0;
				end
				if (item.button_start_stop || n_beep_cnt > BEEP_LIMIT) begin
					n_mode   = MODE_SET;
					n_entry  = 1'b0;
					n_beeper = 1'b0;
				end
			end
		endcase
	end

	// Result of this step
	always_comb begin
		result.mode              = n_mode;
		result.preset_seconds    = n_preset;
		result.remaining_seconds = (n_elapsed < 16'(n_preset))
		                           ? PRESET_W'(16'(n_preset) - n_elapsed) : '0;
		result.show_remaining    = !ran_set;
		result.beeper_on         = n_beeper;
		result.beep_tone         = n_tone;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SET;
			entry_q    <= 1'b0;
			preset_q   <= '0;
			saved_q    <= '0;
			cur_div_q  <= '0;
			cur_mod_q  <= '0;
			run_div_q  <= '0;
			run_mod_q  <= '0;
			elapsed_q  <= '0;
			phase_q    <= '0;
			beep_cnt_q <= '0;
			tone_q     <= TONE_START;
			beeper_q   <= 1'b0;
		end else if (step_en) begin
			mode_q     <= n_mode;
			entry_q    <= n_entry;
			preset_q   <= n_preset;
			saved_q    <= n_saved;
			cur_div_q  <= n_cur_div;
			cur_mod_q  <= n_cur_mod;
			run_div_q  <= n_run_div;
			run_mod_q  <= n_run_mod;
			elapsed_q  <= n_elapsed;
			phase_q    <= n_phase;
			beep_cnt_q <= n_beep_cnt;
			tone_q     <= n_tone;
			beeper_q   <= n_beeper;
		end
	end

	// Checks
	`CDT_ASSERT_NEXT(a_set_start_runs, step_en && mode_q == MODE_SET && item.button_start_stop, mode_q == MODE_RUNNING, "start in set mode did not enter running")
	`CDT_ASSERT_NEXT(a_beep_stop, step_en && mode_q == MODE_BEEPING && item.button_start_stop, mode_q == MODE_SET && !beeper_q, "start while beeping did not silence")
	`CDT_ASSERT_IMP(a_preset_range, mode_q != MODE_SET || entry_q, 16'(preset_q) <= PRESET_LIM && 16'(saved_q) <= PRESET_LIM, "preset beyond limit")

endmodule

`default_nettype wire

### design/countdown_timer_controller_core.sv
// Countdown timer controller. Each stream transaction on s_axis is one polling step (an
// optional timer tick plus four button press events); each produces exactly one result
// transaction on m_axis carrying mode, preset, remaining time, display flag and beeper
// state. The step passes an input register, the mode logic, then the result register;
// throughput is one step per cycle, limited only by m_axis_tready. The preset step size is
// written through cfg_we/cfg_wdata (reset value 10); the user must write it only while no
// step is in flight, as the block itself does not enforce this. No start-up sweep.
`default_nettype none

`include "countdown_timer_controller_core_macros.svh"

module countdown_timer_controller_core import cdt_pkg::*; #(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// preset_step
	input  wire logic        cfg_we,
	input  wire logic [8:0]  cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tick, button_small_step, button_large_step, button_recall, button_start_stop
	input  wire logic [7:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// mode[1:0], preset_seconds[10:2], remaining_seconds[19:11], show_remaining[20],
	// beeper_on[21], beep_tone[45:22]
	output logic [47:0]      m_axis_tdata
);

	logic [PRESET_W-1:0] preset_step_q;
	logic                v_s1;
	item_t               item_s1;
	logic                v_s2;
	result_t             res_s2;
	result_t             res_next;
	logic                advance;

	// Step moves into the result register when that register is free or being taken
	assign advance       = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || advance;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_step_q <= PRESET_STEP_RESET;
		end else if (cfg_we) begin
			preset_step_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_t'(s_axis_tdata[ITEM_W-1:0]);
		end
	end

	cdt_engine #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.item       (item_s1),
		.preset_step(preset_step_q),
		.result     (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {(48 - RESULT_W)'(0), res_s2};

	// Checks
	`CDT_ASSERT_NEXT(a_result_loaded, advance, m_axis_tvalid, "step did not reach the result register")
	`CDT_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`CDT_ASSERT_IMP(a_ready_when_empty, !v_s1, s_axis_tready, "input refused while stage empty")

endmodule

`default_nettype wire

### sim/countdown_timer_controller_core_tb.sv
module countdown_timer_controller_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdt_pkg::*;

	localparam int          TPS        = TICKS_PER_SECOND_DEF;
	localparam logic [31:0] TICK_DIV   = TPS;
	localparam int          IDLE_LIMIT = 2000;
	localparam int          SHOWN_MAX  = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [8:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;

	// Timer state as the testbench sees it
	logic [8:0]  step_seconds;
	mode_t       tmr_mode;
	logic        tmr_entered;
	logic [8:0]  tmr_preset;
	logic [8:0]  tmr_saved;
	logic [31:0] tmr_ticks;
	logic [31:0] tmr_run_ticks;
	logic [15:0] tmr_elapsed;
	logic [23:0] tmr_tone;
	logic        tmr_beeper;

	result_t     pending_results[$];
	int          error_count = 0;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          quiet_cycles = 0;
	logic        hold_alarm;
	int          alarms_held;

	countdown_timer_controller_core #(
		.TICKS_PER_SECOND(TPS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic item_t poll(input bit tick, input bit small_btn, input bit large_btn,
			input bit recall_btn, input bit start_btn);
		item_t it;
		it.tick              = tick;
		it.button_small_step = small_btn;
		it.button_large_step = large_btn;
		it.button_recall     = recall_btn;
		it.button_start_stop = start_btn;
		return it;
	endfunction

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= SHOWN_MAX) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
	endfunction

	function automatic void change_mode(input mode_t m);
		tmr_mode    = m;
		tmr_entered = 1'b0;
	endfunction

	// Preset plus an amount, wrapping to zero past the maximum
	function automatic logic [8:0] raised_preset(input logic [31:0] amount);
		logic [31:0] sum;
		sum = {23'd0, tmr_preset} + amount;
		return (sum <= PRESET_MAX) ? sum[8:0] : 9'd0;
	endfunction

	// One polling step of the timer; returns the result it produces
	function automatic result_t timer_poll_step(input item_t it);
		result_t     r;
		logic [31:0] secs;
		logic [31:0] phase;
		bit          in_set;
		in_set = 1'b0;
		if (it.tick) begin
			tmr_ticks = tmr_ticks + 32'd1;
		end
		case (tmr_mode)
			MODE_SET: begin
				in_set = 1'b1;
				if (!tmr_entered) begin
					tmr_entered = 1'b1;
					tmr_preset  = '0;
				end
				// fixed button order: small, recall, large, start
				if (it.button_small_step) begin
					tmr_preset = raised_preset({23'd0, step_seconds});
				end
				if (it.button_recall) begin
					tmr_preset = tmr_saved;
				end
				if (it.button_large_step) begin
					tmr_preset = raised_preset({23'd0, step_seconds} * LARGE_STEP_FACTOR);
				end
				if (it.button_start_stop) begin
					tmr_saved     = tmr_preset;
					change_mode(MODE_RUNNING);
					tmr_run_ticks = '0;
				end
			end
			MODE_RUNNING: begin
				if (!tmr_entered) begin
					tmr_entered = 1'b1;
					tmr_ticks   = '0;
				end
				secs        = tmr_ticks + tmr_run_ticks;
				secs        = secs / TICK_DIV;
				tmr_elapsed = (secs > 32'hFFFF) ? 16'hFFFF : secs[15:0];
				if (tmr_elapsed >= {7'd0, tmr_preset}) begin
					change_mode(MODE_BEEPING);
				end
				// pause wins over reaching the preset
				if (it.button_start_stop) begin
					change_mode(MODE_PAUSED);
					tmr_run_ticks = tmr_run_ticks + tmr_ticks;
				end
			end
			MODE_PAUSED: begin
				tmr_entered = 1'b1;
				if (it.button_start_stop && tmr_elapsed < {7'd0, tmr_preset}) begin
					change_mode(MODE_RUNNING);
				end
				if (it.button_small_step || it.button_large_step) begin
					change_mode(MODE_SET);
				end
			end
			default: begin
				if (!tmr_entered) begin
					tmr_ticks   = '0;
					tmr_entered = 1'b1;
					tmr_tone    = TONE_START;
				end
				// on in the first half of each two-second beep period, off in the second
				phase = tmr_ticks % (2 * TICK_DIV);
				if (phase < TICK_DIV) begin
					tmr_tone   = tmr_tone + TONE_STEP;
					tmr_beeper = 1'b1;
				end
				if (phase > TICK_DIV) begin
					tmr_beeper = 1'b0;
				end
				if (it.button_start_stop || tmr_ticks > BEEP_SECONDS * TICK_DIV) begin
					change_mode(MODE_SET);
					tmr_beeper = 1'b0;
				end
			end
		endcase
		r.mode              = tmr_mode;
		r.preset_seconds    = tmr_preset;
		r.remaining_seconds = (tmr_elapsed < {7'd0, tmr_preset})
				? tmr_preset - tmr_elapsed[8:0] : 9'd0;
		r.show_remaining    = !in_set;
		r.beeper_on         = tmr_beeper;
		r.beep_tone         = tmr_tone;
		return r;
	endfunction

	// Next random step, shaped by the mode the timer is in
	function automatic item_t pick_poll_item();
		item_t it;
		it = '0;
		case (tmr_mode)
			MODE_SET: begin
				it.tick              = chance(50);
				it.button_small_step = chance(35);
				it.button_recall     = chance(8);
				it.button_large_step = chance(4);
				it.button_start_stop = chance(12);
			end
			MODE_RUNNING: begin
				// long presets get paused and abandoned
				it.tick              = chance(92);
				it.button_start_stop = chance(tmr_preset > 9'd4 ? 10 : 1);
				it.button_small_step = chance(3);
				it.button_large_step = chance(3);
				it.button_recall     = chance(3);
			end
			MODE_PAUSED: begin
				it.tick              = chance(50);
				it.button_start_stop = chance(30);
				it.button_small_step = chance(tmr_preset > 9'd4 ? 30 : 6);
				it.button_large_step = chance(3);
				it.button_recall     = chance(5);
			end
			default: begin
				// let the first alarm and a few later ones run out on their own
				if (!tmr_entered) begin
					hold_alarm = (alarms_held == 0) || chance(10);
					if (hold_alarm) begin
						alarms_held++;
					end
				end
				it.tick              = chance(92);
				it.button_start_stop = !hold_alarm && chance(2);
				it.button_small_step = chance(3);
				it.button_large_step = chance(3);
				it.button_recall     = chance(3);
			end
		endcase
		return it;
	endfunction

	// Present one step; called and returns at a falling edge
	task automatic send_poll(input item_t it);
		while (chance(send_idle_pct)) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'd0, it};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(timer_poll_step(it));
		@(negedge clk);
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_step_seconds(input logic [8:0] value);
		cfg_we       <= 1'b1;
		cfg_wdata    <= value;
		step_seconds  = value;
		@(negedge clk);
		cfg_we       <= 1'b0;
	endtask

	// Preset arithmetic at the register extremes
	task automatic test_preset_arithmetic();
		send_poll(poll(0, 1, 0, 0, 0));
		send_poll(poll(1, 1, 0, 1, 0));
		send_poll(poll(0, 0, 1, 0, 0));
		send_poll(poll(0, 1, 0, 0, 0));
		wait_results_drained();
		write_step_seconds(9'd300);
		send_poll(poll(0, 1, 0, 0, 0));
		send_poll(poll(0, 1, 0, 0, 0));
		send_poll(poll(0, 0, 1, 0, 0));
		wait_results_drained();
		write_step_seconds(9'd0);
		send_poll(poll(1, 1, 1, 0, 0));
		wait_results_drained();
		write_step_seconds(9'd511);
		send_poll(poll(0, 1, 0, 0, 0));
		send_poll(poll(0, 0, 1, 0, 0));
	endtask

	// Walk through every mode and the tie-break cases
	task automatic test_mode_transitions();
		wait_results_drained();
		write_step_seconds(9'd1);
		send_poll(poll(0, 1, 0, 0, 0));
		// every button in set mode at once
		send_poll(poll(1, 1, 1, 1, 1));
		// tick lost on running entry
		send_poll(poll(1, 0, 0, 0, 0));
		send_poll(poll(1, 1, 1, 1, 1));
		send_poll(poll(0, 0, 0, 0, 1));
		send_poll(poll(1, 0, 0, 0, 1));
		// start and step while paused: set wins
		send_poll(poll(0, 1, 0, 0, 1));
		// zero preset goes straight to beeping
		send_poll(poll(0, 0, 0, 0, 1));
		send_poll(poll(1, 0, 0, 0, 0));
		send_poll(poll(1, 0, 0, 0, 0));
		send_poll(poll(0, 0, 0, 0, 0));
		send_poll(poll(0, 0, 0, 0, 1));
		send_poll(poll(0, 0, 0, 1, 0));
	endtask

	// Random polling with given idle and stall rates
	task automatic test_random_polling(input int idle_pct, input int stall_pct,
			input logic [8:0] step, input int count);
		int i;
		wait_results_drained();
		write_step_seconds(step);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (i = 0; i < count; i++) begin
			// hold off midway until everything is back
			if (i == count / 2) begin
				wait_results_drained();
			end
			send_poll(pick_poll_item());
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Result side back-pressure
	always @(negedge clk) begin
		m_axis_tready <= !chance(recv_stall_pct);
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[RESULT_W-1:0]);
			if (pending_results.size() == 0) begin
				flag_error($sformatf("result %h with none expected", m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (got.mode !== want.mode)
					flag_error($sformatf("mode exp %0d got %0d", want.mode, got.mode));
				if (got.preset_seconds !== want.preset_seconds)
					flag_error($sformatf("preset_seconds exp %0d got %0d",
							want.preset_seconds, got.preset_seconds));
				if (got.remaining_seconds !== want.remaining_seconds)
					flag_error($sformatf("remaining_seconds exp %0d got %0d",
							want.remaining_seconds, got.remaining_seconds));
				if (got.show_remaining !== want.show_remaining)
					flag_error($sformatf("show_remaining exp %0b got %0b",
							want.show_remaining, got.show_remaining));
				if (got.beeper_on !== want.beeper_on)
					flag_error($sformatf("beeper_on exp %0b got %0b",
							want.beeper_on, got.beeper_on));
				if (got.beep_tone !== want.beep_tone)
					flag_error($sformatf("beep_tone exp %0d got %0d",
							want.beep_tone, got.beep_tone));
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("countdown_timer_controller_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_alarm     = 1'b0;
		alarms_held    = 0;
		// timer state after reset
		step_seconds   = PRESET_STEP_RESET;
		tmr_mode       = MODE_SET;
		tmr_entered    = 1'b0;
		tmr_preset     = '0;
		tmr_saved      = '0;
		tmr_ticks      = '0;
		tmr_run_ticks  = '0;
		tmr_elapsed    = '0;
		tmr_tone       = TONE_START;
		tmr_beeper     = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_preset_arithmetic();
		test_mode_transitions();
		test_random_polling(0, 0, 9'd1, 490);
		test_random_polling(71, 0, 9'd2, 490);
		test_random_polling(0, 71, 9'd1, 490);
		test_random_polling(18, 18, 9'd3, 490);

		wait_results_drained();
		repeat (4) @(posedge clk);
		if (error_count == 0) begin
			$display("countdown_timer_controller_core test passed");
		end else begin
			$display("countdown_timer_controller_core test failed");
		end
		$finish;
	end

endmodule
